/* rtl/core/mwo_pkg.sv */
// Shared constants, types and elaboration-time helpers for the wave oscillator.
package mwo_pkg;

    // Parameter defaults
    localparam int CHANNELS_DEF    = 2;
    localparam int TABLE_BITS_DEF  = 10;
    localparam int SAMPLE_BITS_DEF = 16;

    // Field and datapath widths
    localparam int WAVE_W    = 2;
    localparam int PERIOD_W  = 16;
    localparam int PHASE_W   = 16;
    localparam int AMP_W     = 15;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int SINE_W    = 15;
    localparam int MUL_A_W   = 17;
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = 4;

    // Divider retires two quotient bits per step, sixteen steps in all
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'd15;

    // Sine table full scale and rounding offset
    localparam logic [AMP_W-1:0] FULL_SCALE = 15'd32767;
    localparam logic [AMP_W-1:0] HALF_SCALE = 15'd16383;

    // Smallest usable period
    localparam logic [PERIOD_W-1:0] PERIOD_MIN = 16'd2;

    // Waveform codes
    localparam logic [WAVE_W-1:0] WAVE_SINE   = 2'd0;
    localparam logic [WAVE_W-1:0] WAVE_SAW    = 2'd1;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAVE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMP    = 2'd2;

    // Register reset values
    localparam logic [WAVE_W-1:0]   WAVE_RESET   = WAVE_SQUARE;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd220;
    localparam logic [AMP_W-1:0]    AMP_RESET    = 15'd32767;

    // pi/2 in unsigned Q2.30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_ROM,
        S_MUL,
        S_MUL_DIV,
        S_DIV,
        S_ADV,
        S_DONE
    } osc_state_t;

    // What the shared divider is working on
    typedef enum logic [1:0] {
        DIV_INDEX,
        DIV_SCALE,
        DIV_SAW,
        DIV_WRAP
    } div_op_t;

    // round(sin(j * (pi/2) / 2^(tb-2)) * 32767), odd Taylor series to x^17 in Q2.30.
    // Used only at elaboration to fill the quarter-wave ROM.
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned j,
                                                       input int unsigned tb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sm;
        longint      r;
        x    = (64'(j) * HALF_PI_Q30) >> (tb - 2);
        x2   = (x * x) >> 30;
        term = x;
        sm   = longint'(x);
        for (int n = 1; n <= 8; n++)
        begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n[0])
                sm = sm - longint'(term);
            else
                sm = sm + longint'(term);
        end
        if (sm < 0)
            sm = 0;
        r = (sm * 32767 + 64'sd536870912) >>> 30;
        if (r > 32767)
            r = 32767;
        return SINE_W'(r);
    endfunction

endpackage

/* rtl/core/multichannel_wave_oscillator_unit.sv */
// Multichannel sine / sawtooth / square oscillator with per-channel phase memory.
//
// Each input transaction names a channel and returns one signed sample of that
// channel, then advances its phase modulo the programmed period. Phases live in
// a small synchronous RAM (one read, one write back per transaction; the write
// lands before the next read, so no forwarding is needed). All divisions by the
// period share one restoring divider that retires two quotient bits per cycle;
// it dominates sine and sawtooth transactions. The sine scaling by full scale
// is a combinational shift-add. A square wave needs only the phase read and
// advance, a sawtooth adds a multiply and a divide, and a sine an index divide,
// quarter-wave ROM, multiply and scale; a full divide for the wrap is added when
// the period was lowered to or below a channel's stored phase. The result waits
// in an output register, so a new transaction can be accepted while the previous
// sample is still stalled. Configuration must be written only while idle by
// the user; the block itself does not enforce it. Period values 0 and 1 behave
// as 2, waveform code 3 gives a square wave, and the phase RAM reads as zero
// until a channel is first used.
module multichannel_wave_oscillator_unit #(
    parameter int CHANNELS    = mwo_pkg::CHANNELS_DEF,
    parameter int TABLE_BITS  = mwo_pkg::TABLE_BITS_DEF,
    parameter int SAMPLE_BITS = mwo_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 channel,
    // sample channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [SAMPLE_BITS-1:0]        sample_value,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [mwo_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mwo_pkg::CFG_W-1:0]            cfg_wdata
);

    import mwo_pkg::*;

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QUARTER = 1 << (TABLE_BITS - 2);
    localparam int J_W     = TABLE_BITS - 1;
    localparam int MAG_W   = DIV_W + 1;

    localparam logic [MAG_W-1:0] POS_MAX = (MAG_W'(1) << (SAMPLE_BITS - 1)) - MAG_W'(1);
    localparam logic [MAG_W-1:0] NEG_MAG = MAG_W'(1) << (SAMPLE_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // Quarter-wave sine ROM, filled at elaboration
    typedef logic [SINE_W-1:0] qtab_t [QUARTER + 1];

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int k = 0; k <= QUARTER; k++)
        begin
            t[k] = quarter_sine(k, TABLE_BITS);
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    // Control state
    osc_state_t               state_reg, state_next;
    div_op_t                  div_op_reg;
    logic [DIV_CNT_W-1:0]     cnt_reg;
    logic                     out_valid_reg;
    logic [CHANNELS-1:0]      phase_vld_reg;

    // Configuration registers
    logic [WAVE_W-1:0]        wave_reg;
    logic [PERIOD_W-1:0]      period_reg;
    logic [AMP_W-1:0]         amp_reg;

    // Phase memory and read port
    logic [PHASE_W-1:0]       phase_mem [CHANNELS];
    logic [PHASE_W-1:0]       rd_phase_reg;
    logic                     rd_vld_reg;

    // Datapath registers
    logic [CH_W-1:0]          ch_reg;
    logic [PHASE_W-1:0]       p_reg;
    logic [PHASE_W-1:0]       nxt_phase_reg;
    logic [MUL_A_W-1:0]       mul_a_reg;
    logic [DIV_W-1:0]         prod_reg;
    logic [DIV_W-1:0]         mag_reg;
    logic                     sign_reg;
    logic [DIV_W-1:0]         dvd_reg;
    logic [PERIOD_W-1:0]      dvs_reg;
    logic [PERIOD_W-1:0]      rem_reg;
    logic [SAMPLE_BITS-1:0]   sample_reg;

    // Combinational helpers
    logic [CH_W-1:0]          ch_idx;
    logic [PERIOD_W-1:0]      per_eff;
    logic [PHASE_W-1:0]       p_rd;
    logic [PHASE_W:0]         p_dbl;
    logic                     ge_half;
    logic [MUL_A_W-1:0]       saw_diff;
    logic [PHASE_W:0]         p_inc;
    logic                     wrap_need;
    logic                     div_last;
    logic                     out_free;
    logic [TABLE_BITS-1:0]    rom_idx;
    logic [1:0]               rom_quad;
    logic [J_W-1:0]           rom_j;
    logic [PERIOD_W:0]        div_t1, div_t2;
    logic                     div_q1, div_q2;
    logic [PERIOD_W-1:0]      div_r1;
    logic [PERIOD_W-1:0]      rem_step;
    logic [DIV_W-1:0]         dvd_step;
    logic [DIV_W-1:0]         scale_x;
    logic [DIV_W-1:0]         scale_q;
    logic [SAMPLE_BITS-1:0]   sample_sat;

    // Channel select (number taken modulo CHANNELS)
    assign ch_idx = (CHANNELS > 1) ? CH_W'(channel) : '0;

    // Effective period and phase read back from memory
    assign per_eff = (period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg;
    assign p_rd    = rd_vld_reg ? rd_phase_reg : '0;

    // Half-period compare and sawtooth numerator magnitude
    assign p_dbl    = {p_rd, 1'b0};
    assign ge_half  = p_dbl >= {1'b0, per_eff};
    assign saw_diff = ge_half ? (p_dbl - {1'b0, per_eff}) : ({1'b0, per_eff} - p_dbl);

    // Phase advance
    assign p_inc     = {1'b0, p_reg} + (PHASE_W + 1)'(1);
    assign wrap_need = p_inc > {1'b0, per_eff};

    // Quarter-wave ROM address from the index quotient
    assign rom_idx  = dvd_reg[TABLE_BITS-1:0];
    assign rom_quad = rom_idx[TABLE_BITS-1 -: 2];
    assign rom_j    = rom_quad[0] ? (J_W'(QUARTER) - J_W'(rom_idx[TABLE_BITS-3:0]))
                                  : J_W'(rom_idx[TABLE_BITS-3:0]);

    // Divider: two restoring steps per cycle
    assign div_t1   = {rem_reg, dvd_reg[DIV_W-1]};
    assign div_q1   = div_t1 >= {1'b0, dvs_reg};
    assign div_r1   = div_q1 ? PERIOD_W'(div_t1 - {1'b0, dvs_reg}) : div_t1[PERIOD_W-1:0];
    assign div_t2   = {div_r1, dvd_reg[DIV_W-2]};
    assign div_q2   = div_t2 >= {1'b0, dvs_reg};
    assign rem_step = div_q2 ? PERIOD_W'(div_t2 - {1'b0, dvs_reg}) : div_t2[PERIOD_W-1:0];
    assign dvd_step = {dvd_reg[DIV_W-3:0], div_q1, div_q2};
    assign div_last = cnt_reg == DIV_LAST;

    // Rounded sine scaling: divide by 2^15-1 as (x + (x >> 15) + 1) >> 15,
    // exact while the quotient stays below 2^15
    assign scale_x = prod_reg + DIV_W'(HALF_SCALE);
    assign scale_q = (scale_x + (scale_x >> AMP_W) + DIV_W'(1)) >> AMP_W;

    // Output slot and saturation to the sample width
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (!sign_reg)
            sample_sat = ({1'b0, mag_reg} > POS_MAX) ? SMP_MAX : SAMPLE_BITS'(mag_reg);
        else
            sample_sat = ({1'b0, mag_reg} > NEG_MAG) ? SMP_MIN
                                                     : SAMPLE_BITS'(~mag_reg + DIV_W'(1));
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and handshake
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                    state_next = S_READ;
            end
            S_READ:
                state_next = S_LOAD;
            S_LOAD:
            begin
                case (wave_reg)
                    WAVE_SINE: state_next = S_DIV;
                    WAVE_SAW:  state_next = S_MUL;
                    default:   state_next = S_ADV;
                endcase
            end
            S_ROM:
                state_next = S_MUL;
            S_MUL:
                state_next = S_MUL_DIV;
            S_MUL_DIV:
                state_next = (div_op_reg == DIV_SCALE) ? S_ADV : S_DIV;
            S_DIV:
            begin
                if (div_last)
                begin
                    case (div_op_reg)
                        DIV_INDEX: state_next = S_ROM;
                        DIV_WRAP:  state_next = S_DONE;
                        default:   state_next = S_ADV;
                    endcase
                end
            end
            S_ADV:
                state_next = wrap_need ? S_DIV : S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control registers: divider count, divider job, output valid, phase valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            div_op_reg    <= DIV_INDEX;
            out_valid_reg <= 1'b0;
            phase_vld_reg <= '0;
        end
        else
        begin
            if (state_reg == S_DIV)
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            else
                cnt_reg <= '0;

            case (state_reg)
                S_LOAD:
                begin
                    if (wave_reg == WAVE_SINE)
                        div_op_reg <= DIV_INDEX;
                    else
                        div_op_reg <= DIV_SAW;
                end
                S_ROM:
                    div_op_reg <= DIV_SCALE;
                S_ADV:
                    div_op_reg <= DIV_WRAP;
                default:
                    ;
            endcase

            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg         <= 1'b1;
                phase_vld_reg[ch_reg] <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg   <= WAVE_RESET;
            period_reg <= PERIOD_RESET;
            amp_reg    <= AMP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WAVE:   wave_reg   <= cfg_wdata[WAVE_W-1:0];
                REG_PERIOD: period_reg <= cfg_wdata[PERIOD_W-1:0];
                REG_AMP:    amp_reg    <= cfg_wdata[AMP_W-1:0];
                default:    ;
            endcase
        end
    end

    // Phase memory: read in S_READ, write back in S_DONE
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            rd_phase_reg <= phase_mem[ch_reg];
            rd_vld_reg   <= phase_vld_reg[ch_reg];
        end
        if (state_reg == S_DONE && out_free)
            phase_mem[ch_reg] <= nxt_phase_reg;
    end

    // Datapath: operand setup, ROM, multiplier, divider, phase advance, output
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    ch_reg <= ch_idx;
            end
            S_LOAD:
            begin
                p_reg <= p_rd;
                case (wave_reg)
                    WAVE_SINE:
                    begin
                        dvd_reg <= DIV_W'(p_rd) << TABLE_BITS;
                        dvs_reg <= per_eff;
                        rem_reg <= '0;
                    end
                    WAVE_SAW:
                    begin
                        mul_a_reg <= saw_diff;
                        sign_reg  <= !ge_half;
                    end
                    default:
                    begin
                        mag_reg  <= DIV_W'(amp_reg);
                        sign_reg <= !ge_half;
                    end
                endcase
            end
            S_ROM:
            begin
                mul_a_reg <= MUL_A_W'(QTAB[rom_j]);
                sign_reg  <= rom_quad[1];
            end
            S_MUL:
                prod_reg <= DIV_W'(mul_a_reg) * DIV_W'(amp_reg);
            S_MUL_DIV:
            begin
                rem_reg <= '0;
                if (div_op_reg == DIV_SCALE)
                begin
                    mag_reg <= scale_q;
                end
                else
                begin
                    dvd_reg <= prod_reg;
                    dvs_reg <= per_eff;
                end
            end
            S_DIV:
            begin
                dvd_reg <= dvd_step;
                rem_reg <= rem_step;
                if (div_last)
                begin
                    case (div_op_reg)
                        DIV_SAW:  mag_reg       <= dvd_step;
                        DIV_WRAP: nxt_phase_reg <= rem_step;
                        default:  ;
                    endcase
                end
            end
            S_ADV:
            begin
                if (wrap_need)
                begin
                    dvd_reg <= DIV_W'(p_inc);
                    dvs_reg <= per_eff;
                    rem_reg <= '0;
                end
                else if (p_inc == {1'b0, per_eff})
                begin
                    nxt_phase_reg <= '0;
                end
                else
                begin
                    nxt_phase_reg <= p_inc[PHASE_W-1:0];
                end
            end
            S_DONE:
            begin
                if (out_free)
                    sample_reg <= sample_sat;
            end
            default:
                ;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = sample_reg;

endmodule

/* tb/multichannel_wave_oscillator_unit_tb.sv */
// Self-checking testbench for the multichannel wave oscillator: directed, pressure and random tests.
module multichannel_wave_oscillator_unit_tb;
    import mwo_pkg::*;

    localparam int LUT_BITS    = TABLE_BITS_DEF;
    localparam int LUT_SIZE    = 1 << LUT_BITS;
    localparam int QTR         = LUT_SIZE / 4;
    localparam int SMP_W       = SAMPLE_BITS_DEF;
    localparam int QUIET_LIMIT = 5000;

    // Codes that the package leaves unnamed
    localparam logic [WAVE_W-1:0]    WAVE_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    channel;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [SMP_W-1:0] sample_value;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_wdata;

    // Oscillator copy used for prediction
    int                      sine_lut [LUT_SIZE];
    logic [WAVE_W-1:0]       wave_sel;
    logic [PERIOD_W-1:0]     period_len;
    logic [AMP_W-1:0]        amp_val;
    logic [PHASE_W-1:0]      osc_phase [CHANNELS_DEF];

    logic signed [SMP_W-1:0] expected_samples [$];
    int                      error_count;
    int                      quiet_cycles;
    int                      hold_left;
    bit                      src_idle;
    bit                      sink_idle;

    multichannel_wave_oscillator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .channel      (channel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_value (sample_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always #2 clk = ~clk;

    // One quarter-wave entry: odd Taylor series in unsigned Q2.30, rounded half up
    function automatic int quarter_wave_entry(input int unsigned j);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned divisor;
        longint          acc;
        longint          r;
        x    = (64'(j) * HALF_PI_Q30) / QTR;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 8; n++)
        begin
            divisor = (2 * n) * (2 * n + 1);
            term    = ((term * x2) >> 30) / divisor;
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        r = (acc * 32767 + (longint'(1) << 29)) >>> 30;
        if (r > 32767)
            r = 32767;
        return int'(r);
    endfunction

    // Full sine table from quarter-wave symmetry
    task automatic build_sine_lut();
        for (int k = 0; k < LUT_SIZE; k++)
        begin
            if (k < QTR)
                sine_lut[k] = quarter_wave_entry(k);
            else if (k < 2 * QTR)
                sine_lut[k] = quarter_wave_entry(2 * QTR - k);
            else if (k < 3 * QTR)
                sine_lut[k] = -quarter_wave_entry(k - 2 * QTR);
            else
                sine_lut[k] = -quarter_wave_entry(4 * QTR - k);
        end
    endtask

    // Sample for a channel at its current phase; advances that phase
    function automatic logic signed [SMP_W-1:0] next_sample(input logic ch);
        longint p;
        longint per;
        longint amp;
        longint s;
        longint prod;
        longint mag;
        longint hi;
        int     idx;
        p   = osc_phase[ch];
        per = (period_len < PERIOD_MIN) ? 2 : period_len;
        amp = amp_val;
        hi  = (longint'(1) << (SMP_W - 1)) - 1;
        case (wave_sel)
            WAVE_SINE:
            begin
                idx  = int'(((p << LUT_BITS) / per) % LUT_SIZE);
                prod = sine_lut[idx] * amp;
                mag  = (prod < 0) ? -prod : prod;
                s    = (mag + 16383) / 32767;
                if (prod < 0)
                    s = -s;
            end
            WAVE_SAW:
                s = ((2 * p - per) * amp) / per;
            default:
                s = (2 * p >= per) ? amp : -amp;
        endcase
        if (s > hi)
            s = hi;
        else if (s < -hi - 1)
            s = -hi - 1;
        osc_phase[ch] = PHASE_W'((p + 1) % per);
        return SMP_W'(s);
    endfunction

    // Register write; the model follows the same masking
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WAVE:   wave_sel   = data[WAVE_W-1:0];
            REG_PERIOD: period_len = data;
            REG_AMP:    amp_val    = data[AMP_W-1:0];
            default:    ;
        endcase
        @(posedge clk);
    endtask

    // One request transaction, with optional random gap ahead of it
    task automatic send_request(input logic ch);
        while (src_idle && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        channel  <= ch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_samples.push_back(next_sample(ch));
    endtask

    // Stop offering and wait until every sample is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_request(1'b0);
        send_request(1'b1);
        wait_drained();
    endtask

    task automatic test_each_waveform();
        logic [WAVE_W-1:0] codes [4];
        codes = '{WAVE_SINE, WAVE_SAW, WAVE_SQUARE, WAVE_SPARE};
        write_reg(REG_PERIOD, 16'd8);
        foreach (codes[i])
        begin
            write_reg(REG_WAVE, CFG_W'(codes[i]));
            send_request(1'b0);
            send_request(1'b1);
            wait_drained();
        end
    endtask

    // Period 0 and 1 both behave as 2
    task automatic test_short_period();
        write_reg(REG_WAVE, CFG_W'(WAVE_SAW));
        write_reg(REG_PERIOD, 16'd0);
        send_request(1'b0);
        send_request(1'b1);
        wait_drained();
        write_reg(REG_PERIOD, 16'd1);
        send_request(1'b0);
        send_request(1'b1);
        wait_drained();
    endtask

    // All-ones writes, then a period cut below the stored phase
    task automatic test_phase_overrun();
        write_reg(REG_WAVE, 16'hFFFF);
        write_reg(REG_PERIOD, 16'hFFFF);
        write_reg(REG_AMP, 16'hFFFF);
        write_reg(REG_WAVE, CFG_W'(WAVE_SAW));
        repeat (6) send_request(1'b0);
        wait_drained();
        write_reg(REG_PERIOD, 16'd3);
        send_request(1'b0);
        send_request(1'b0);
        wait_drained();
        write_reg(REG_WAVE, CFG_W'(WAVE_SINE));
        write_reg(REG_PERIOD, 16'd2);
        send_request(1'b1);
        wait_drained();
    endtask

    // Zero amplitude, then a write to the unused index that must not land
    task automatic test_zero_amp_and_spare_index();
        write_reg(REG_AMP, 16'h0000);
        send_request(1'b0);
        wait_drained();
        write_reg(REG_SPARE, 16'h5A5A);
        send_request(1'b1);
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        src_idle = 1'b0;
        write_reg(REG_WAVE, CFG_W'(WAVE_SAW));
        write_reg(REG_PERIOD, 16'd50);
        write_reg(REG_AMP, 16'd12345);
        hold_left = 300;
        repeat (24) send_request(1'(($urandom_range(1))));
        wait_drained();
        src_idle = 1'b1;
    endtask

    // Random settings per phase; one phase runs with no idling at all
    task automatic test_random_phases();
        int          pick;
        logic [15:0] per;
        logic [15:0] amp;
        for (int ph = 0; ph < 9; ph++)
        begin
            src_idle  = (ph != 4);
            sink_idle = (ph != 4);
            pick = $urandom_range(99);
            if (pick < 55)
                per = 16'($urandom_range(64, 2));
            else if (pick < 80)
                per = 16'($urandom_range(1024, 65));
            else if (pick < 93)
                per = 16'($urandom_range(65535, 1025));
            else
                case ($urandom_range(3))
                    0:       per = 16'd0;
                    1:       per = 16'd1;
                    2:       per = 16'd2;
                    default: per = 16'hFFFF;
                endcase
            pick = $urandom_range(9);
            if (pick == 0)
                amp = 16'd0;
            else if (pick == 1)
                amp = 16'h7FFF;
            else
                amp = 16'($urandom_range(65535));
            write_reg(REG_WAVE, 16'($urandom_range(65535)));
            write_reg(REG_PERIOD, per);
            write_reg(REG_AMP, amp);
            if ($urandom_range(3) == 0)
                write_reg(REG_SPARE, 16'($urandom_range(65535)));
            repeat (100) send_request(1'(($urandom_range(1))));
            wait_drained();
        end
    endtask

    // Receiver: long hold-off when asked, else random stalls while sink idling is on
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else if (sink_idle)
                out_stall <= ($urandom_range(99) < 26);
            else
                out_stall <= 1'b0;
        end
    end

    // Compare each sample transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected sample, expected none actual %0d",
                         $time, sample_value);
            end
            else if (sample_value !== expected_samples[0])
            begin
                error_count++;
                $display("%0t: sample mismatch, expected %0d actual %0d",
                         $time, expected_samples[0], sample_value);
                void'(expected_samples.pop_front());
            end
            else
                void'(expected_samples.pop_front());
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        channel      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_WAVE;
        cfg_wdata    = '0;
        error_count  = 0;
        quiet_cycles = 0;
        hold_left    = 0;
        src_idle     = 1'b1;
        sink_idle    = 1'b1;
        wave_sel     = WAVE_RESET;
        period_len   = PERIOD_RESET;
        amp_val      = AMP_RESET;
        foreach (osc_phase[i])
            osc_phase[i] = '0;
        build_sine_lut();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_each_waveform();
        test_short_period();
        test_phase_overrun();
        test_zero_amp_and_spare_index();
        test_backpressure();
        test_random_phases();

        wait_drained();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/core/mwo_pkg.sv
rtl/core/multichannel_wave_oscillator_unit.sv
tb/multichannel_wave_oscillator_unit_tb.sv
